>>> src/bubble_sorter_top_macros.svh
// Assertion macros for the bubble sorter top level.
// Each macro expands to one labeled concurrent assertion on clk_i and rst_ni.
`ifndef BUBBLE_SORTER_TOP_MACROS_SVH
`define BUBBLE_SORTER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bsort_pkg.sv
// Shared types for the bubble sorter: controller states and the
// command/status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package bsort_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_TOP   = 7'b0000100,
    S_CAP   = 7'b0001000,
    S_CMP   = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } bsort_state_e;

  typedef struct packed {
    logic load;   // store an accepted item
    logic setup;  // reset pass bound and output index
    logic top;    // read the top entry of the set
    logic cap;    // capture top entry into the carry register
    logic cmp;    // compare-swap carry against the entry below
    logic fin;    // drop the carry into the pass bound slot
    logic emit;   // read out one sorted entry
    logic clr;    // set finished, clear count and overflow
  } bsort_cmd_t;

  typedef struct packed {
    logic n_small;    // set holds at most one element
    logic pass_end;   // compare at the pass bound
    logic last_pass;  // no further pass needed
    logic emit_end;   // reading the final element
  } bsort_stat_t;

endpackage

>>> src/bsort_ctrl.sv
// Controller state machine of the bubble sorter.
// Uses bsort_pkg for the state type and the command/status bundles.
`timescale 1ns / 1ps

module bsort_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic                  last_item_i,
  input  bsort_pkg::bsort_stat_t stat_i,
  output bsort_pkg::bsort_cmd_t  cmd_o,
  output logic                  busy
);
  import bsort_pkg::*;

  bsort_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (last_item_i) begin
            state_d = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = stat_i.n_small ? S_EMIT : S_TOP;
      end
      S_TOP: begin
        cmd_o.top = 1'b1;
        state_d   = S_CAP;
      end
      S_CAP: begin
        cmd_o.cap = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (stat_i.pass_end) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = stat_i.last_pass ? S_EMIT : S_TOP;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (stat_i.emit_end) begin
          cmd_o.clr = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> src/bsort_dp.sv
// Datapath of the bubble sorter: element memory, indexes, carry register,
// signed compare and the registered result stage. Uses bsort_pkg.
`timescale 1ns / 1ps

module bsort_dp #(
  parameter int MAX_ITEMS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bsort_pkg::bsort_cmd_t             cmd_i,
  output bsort_pkg::bsort_stat_t            stat_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_data_i,
  input  logic signed [bsort_pkg::DATA_W-1:0] value_i,
  output logic signed [bsort_pkg::DATA_W-1:0] sorted_value_o,
  output logic                              last_result_o,
  output logic                              dropped_o,
  output logic                              result_strobe_o
);
  import bsort_pkg::*;

  localparam int AW  = $clog2(MAX_ITEMS);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int CW1 = CW + 1;

  logic signed [DATA_W-1:0] mem [MAX_ITEMS];
  logic signed [DATA_W-1:0] rdata_q;
  logic signed [DATA_W-1:0] carry_q, carry_d;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          desc_q;
  logic [AW-1:0] bound_q, bound_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] k_q, k_d;
  logic          emit_q, emit_last_q, emit_drop_q;

  logic [CW-1:0]     cnt_m1;
  logic [AW-1:0]     last_addr;
  logic [AW-1:0]     bound_p1;
  logic [CW1-1:0]    bound_p2;
  logic              has_room;
  logic              swap;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic signed [DATA_W-1:0] wdata;

  assign cnt_m1    = count_q - CW'(1);
  assign last_addr = cnt_m1[AW-1:0];
  assign bound_p1  = bound_q + AW'(1);
  assign bound_p2  = CW1'(bound_q) + CW1'(2);
  assign has_room  = (count_q < CW'(MAX_ITEMS));

  // Carry holds the upper neighbor; swap on strict order violation only.
  assign swap = desc_q ? (rdata_q < carry_q) : (carry_q < rdata_q);

  assign stat_o.n_small   = (count_q <= CW'(1));
  assign stat_o.pass_end  = (cur_q == bound_p1);
  assign stat_o.last_pass = (bound_p2 >= CW1'(count_q));
  assign stat_o.emit_end  = (k_q == last_addr);

  always_comb begin
    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = value_i;
    raddr = '0;
    if (cmd_i.load) begin
      we = has_room;
    end
    if (cmd_i.cmp) begin
      we    = 1'b1;
      waddr = cur_q;
      wdata = swap ? rdata_q : carry_q;
      raddr = cur_q - AW'(2);
    end
    if (cmd_i.fin) begin
      we    = 1'b1;
      waddr = bound_q;
      wdata = carry_q;
    end
    if (cmd_i.top) begin
      raddr = last_addr;
    end
    if (cmd_i.cap) begin
      raddr = cur_q - AW'(1);
    end
    if (cmd_i.emit) begin
      raddr = k_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    bound_d = bound_q;
    cur_d   = cur_q;
    k_d     = k_q;
    carry_d = carry_q;
    if (cmd_i.load) begin
      if (has_room) begin
        count_d = count_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.setup) begin
      bound_d = '0;
      k_d     = '0;
    end
    if (cmd_i.top) begin
      cur_d = last_addr;
    end
    if (cmd_i.cap) begin
      carry_d = rdata_q;
    end
    if (cmd_i.cmp) begin
      cur_d = cur_q - AW'(1);
      if (!swap) begin
        carry_d = rdata_q;
      end
    end
    if (cmd_i.fin) begin
      bound_d = bound_p1;
    end
    if (cmd_i.emit) begin
      k_d = k_q + AW'(1);
    end
    if (cmd_i.clr) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      desc_q      <= 1'b0;
      bound_q     <= '0;
      cur_q       <= '0;
      k_q         <= '0;
      emit_q      <= 1'b0;
      emit_last_q <= 1'b0;
      emit_drop_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      bound_q     <= bound_d;
      cur_q       <= cur_d;
      k_q         <= k_d;
      emit_q      <= cmd_i.emit;
      emit_last_q <= cmd_i.emit & stat_o.emit_end;
      emit_drop_q <= ovf_q;
      if (cfg_we_i) begin
        desc_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

  assign sorted_value_o  = rdata_q;
  assign result_strobe_o = emit_q;
  assign last_result_o   = emit_last_q;
  assign dropped_o       = emit_drop_q;

endmodule

>>> src/bubble_sorter_top.sv
// Top level of the bubble sorter: controller plus datapath.
// Depends on bsort_pkg, bsort_ctrl, bsort_dp and the assertion macro header.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+-----------------------------------------
//   input     | start high, busy low      | value_i, last_item_i
//   result    | result_strobe_o, 1 cycle  | sorted_value_o, last_result_o, dropped_o
//   config    | cfg_we_i                  | cfg_data_i (descending)
//
// Loading takes one cycle per item. After the last item of a set the block stays
// busy for its sorting passes and the read-out; a set of at most one element goes
// from setup straight to read-out. The compare-swap loop does one memory
// read and one write per cycle on the single element memory. Results leave
// one per cycle, the final one in the first cycle with busy low. Reset clears the
// control state; the memory is not cleared.
// The receiver cannot stall; results are never held back.
`timescale 1ns / 1ps

module bubble_sorter_top #(
  parameter int MAX_ITEMS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [bsort_pkg::DATA_W-1:0] value_i,
  input  logic                              last_item_i,
  input  logic                              cfg_we_i,
  input  logic                              cfg_data_i,
  output logic                              result_strobe_o,
  output logic signed [bsort_pkg::DATA_W-1:0] sorted_value_o,
  output logic                              last_result_o,
  output logic                              dropped_o
);
  import bsort_pkg::*;

  `include "bubble_sorter_top_macros.svh"

  bsort_cmd_t  cmd;
  bsort_stat_t stat;
  logic        accept;

  assign accept = start & ~busy;

  bsort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (accept),
    .last_item_i (last_item_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  bsort_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .value_i         (value_i),
    .sorted_value_o  (sorted_value_o),
    .last_result_o   (last_result_o),
    .dropped_o       (dropped_o),
    .result_strobe_o (result_strobe_o)
  );

  // A result can only come out of a read issued while the block was busy.
  `BS_ASSERT_NOW(a_strobe_after_busy, result_strobe_o, $past(busy), "result without sort")
  // A new set needs at least a load and a setup cycle before its first result.
  `BS_ASSERT_NEXT(a_gap_after_last, result_strobe_o && last_result_o, !result_strobe_o,
    "result right after final")
  // The controller drives at most one datapath operation per cycle.
  `BS_ASSERT_NOW(a_one_op, 1'b1,
    $onehot0({cmd.load, cmd.setup, cmd.top, cmd.cap, cmd.cmp, cmd.fin, cmd.emit}),
    "conflicting datapath commands")

endmodule
